@@ src/scc_pkg.sv @@
// Shared types, constants and codes of the segment crossing checker.
package scc_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int COORD_BITS = 10;
	localparam int ADDR_W = $clog2(MAX_SEGMENTS);
	localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int CROSS_W = PROD_W + 1;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_CHECK  = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] ax;
		logic [COORD_BITS-1:0] ay;
		logic [COORD_BITS-1:0] bx;
		logic [COORD_BITS-1:0] by;
	} segment_t;

	typedef struct packed {
		logic busy;
		logic valid;
		logic hit;
	} cross_res_t;

endpackage

@@ src/scc_seg_table.sv @@
// Segment table memory with one write port and one registered read port.
module scc_seg_table
	import scc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  segment_t          wr_seg,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output segment_t          rd_seg,
	output logic              rd_valid
);

	segment_t mem_q [MAX_SEGMENTS];
	segment_t rd_seg_q;
	logic     rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_seg;
		end
		if (rd_en) begin
			rd_seg_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= rd_en;
		end
	end

	assign rd_seg = rd_seg_q;
	assign rd_valid = rd_valid_q;

endmodule

@@ src/scc_cross_unit.sv @@
// Two-stage pipelined proper-crossing test of a stored segment against the new one.
module scc_cross_unit
	import scc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       seg_valid,
	input  segment_t   stored_seg,
	input  segment_t   new_seg,
	output cross_res_t res
);

	logic signed [DIFF_W-1:0] s_dx, s_dy, n_dx, n_dy;
	logic signed [DIFF_W-1:0] na_sx, na_sy, nb_sx, nb_sy;
	logic signed [DIFF_W-1:0] sa_nx, sa_ny, sb_nx, sb_ny;
	logic                     shares;

	logic signed [PROD_W-1:0] p1_s1, q1_s1, p2_s1, q2_s1;
	logic signed [PROD_W-1:0] p3_s1, q3_s1, p4_s1, q4_s1;
	logic                     skip_s1;
	logic                     valid_s1;

	logic signed [CROSS_W-1:0] v1, v2, v3, v4;
	logic                      split_s, split_n;
	logic                      hit_s2;
	logic                      valid_s2;

	function automatic logic signed [DIFF_W-1:0] diff(
		input logic [COORD_BITS-1:0] a,
		input logic [COORD_BITS-1:0] b
	);
		diff = $signed({1'b0, a}) - $signed({1'b0, b});
	endfunction

	function automatic logic opposite(
		input logic signed [CROSS_W-1:0] a,
		input logic signed [CROSS_W-1:0] b
	);
		opposite = (a > 0 && b < 0) || (a < 0 && b > 0);
	endfunction

	always_comb begin
		s_dx = diff(stored_seg.bx, stored_seg.ax);
		s_dy = diff(stored_seg.by, stored_seg.ay);
		n_dx = diff(new_seg.bx, new_seg.ax);
		n_dy = diff(new_seg.by, new_seg.ay);
		na_sx = diff(new_seg.ax, stored_seg.ax);
		na_sy = diff(new_seg.ay, stored_seg.ay);
		nb_sx = diff(new_seg.bx, stored_seg.ax);
		nb_sy = diff(new_seg.by, stored_seg.ay);
		sa_nx = diff(stored_seg.ax, new_seg.ax);
		sa_ny = diff(stored_seg.ay, new_seg.ay);
		sb_nx = diff(stored_seg.bx, new_seg.ax);
		sb_ny = diff(stored_seg.by, new_seg.ay);
		shares =
			(stored_seg.ax == new_seg.ax && stored_seg.ay == new_seg.ay) ||
			(stored_seg.ax == new_seg.bx && stored_seg.ay == new_seg.by) ||
			(stored_seg.bx == new_seg.ax && stored_seg.by == new_seg.ay) ||
			(stored_seg.bx == new_seg.bx && stored_seg.by == new_seg.by);
	end

	always_ff @(posedge clk) begin
		p1_s1 <= PROD_W'(s_dx * na_sy);
		q1_s1 <= PROD_W'(s_dy * na_sx);
		p2_s1 <= PROD_W'(s_dx * nb_sy);
		q2_s1 <= PROD_W'(s_dy * nb_sx);
		p3_s1 <= PROD_W'(n_dx * sa_ny);
		q3_s1 <= PROD_W'(n_dy * sa_nx);
		p4_s1 <= PROD_W'(n_dx * sb_ny);
		q4_s1 <= PROD_W'(n_dy * sb_nx);
		skip_s1 <= shares;
	end

	always_comb begin
		v1 = CROSS_W'(p1_s1) - CROSS_W'(q1_s1);
		v2 = CROSS_W'(p2_s1) - CROSS_W'(q2_s1);
		v3 = CROSS_W'(p3_s1) - CROSS_W'(q3_s1);
		v4 = CROSS_W'(p4_s1) - CROSS_W'(q4_s1);
		split_s = opposite(v1, v2);
		split_n = opposite(v3, v4);
	end

	always_ff @(posedge clk) begin
		hit_s2 <= !skip_s1 && split_s && split_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= seg_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign res.busy = valid_s1 || valid_s2;
	assign res.valid = valid_s2;
	assign res.hit = hit_s2;

endmodule

@@ src/segment_crossing_checker.sv @@
// Top level of the segment crossing checker: control, table and crossing pipeline.
//
// Commands arrive as beats on the cmd channel (cmd_valid, cmd_stall) carrying an action
// and the two endpoints of a segment. Every command yields exactly one beat on the
// rsp channel (rsp_valid, rsp_stall) with crosses, table_full and stored_count.
// Insert appends the segment to the table or, when the table already holds
// MAX_SEGMENTS entries, drops it and sets table_full. Clear empties the table.
// Check reads the stored segments one per cycle through the single read port of
// the table memory and feeds them to a two-stage crossing pipeline; crosses is set
// when any stored segment that shares no endpoint with the new one crosses it
// inside both segments.
// Insert, clear, the unused action and a check of an empty table go straight from the
// idle state to the response state. A check of a table holding N segments first scans:
// it reads each stored segment in turn, one table read per cycle, then waits until the
// registered table read and the crossing pipeline have drained before it moves to the
// response state. The next command is taken once the response state has passed its beat on.
// One command is worked on at a time; cmd_stall is high until its response has
// been placed in the output register, and that register holds its beat while
// rsp_stall is high, so a new command may be taken while a response waits.
// Reset empties the table and clears both channels; no clearing pass is needed.
module segment_crossing_checker
	import scc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic [1:0]            action,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic                  crosses,
	output logic                  table_full,
	output logic [CNT_W-1:0]      stored_count
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             crosses_q;
	logic             full_q;
	segment_t         new_q;
	logic             rsp_valid_q;
	logic             rsp_crosses_q;
	logic             rsp_full_q;
	logic [CNT_W-1:0] rsp_count_q;

	segment_t   cmd_seg;
	logic       cmd_take;
	logic       at_max;
	logic       wr_en;
	logic       rd_en;
	segment_t   rd_seg;
	logic       rd_valid;
	cross_res_t cross_res;
	logic       scan_done;
	logic       rsp_free;

	assign cmd_seg = '{ax: start_x, ay: start_y, bx: end_x, by: end_y};
	assign cmd_take = cmd_valid && (state_q == ST_IDLE);
	assign at_max = (count_q == CNT_W'(MAX_SEGMENTS));
	assign wr_en = cmd_take && (action == ACT_INSERT) && !at_max;
	assign rd_en = (state_q == ST_SCAN) && (rd_idx_q < count_q);
	assign scan_done = (state_q == ST_SCAN) && (rd_idx_q == count_q) && !rd_valid &&
		!cross_res.busy;
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	scc_seg_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (count_q[ADDR_W-1:0]),
		.wr_seg   (cmd_seg),
		.rd_en    (rd_en),
		.rd_addr  (rd_idx_q[ADDR_W-1:0]),
		.rd_seg   (rd_seg),
		.rd_valid (rd_valid)
	);

	scc_cross_unit u_cross (
		.clk        (clk),
		.arst_n     (arst_n),
		.seg_valid  (rd_valid),
		.stored_seg (rd_seg),
		.new_seg    (new_q),
		.res        (cross_res)
	);

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			new_q <= cmd_seg;
		end
		if (state_q == ST_RESP && rsp_free) begin
			rsp_crosses_q <= crosses_q;
			rsp_full_q <= full_q;
			rsp_count_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_idx_q <= '0;
			crosses_q <= 1'b0;
			full_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_RESP && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						crosses_q <= 1'b0;
						full_q <= (action == ACT_INSERT) && at_max;
						rd_idx_q <= '0;
						if (action == ACT_CHECK && count_q != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
						case (action)
							ACT_INSERT: begin
								if (!at_max) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (cross_res.valid && cross_res.hit) begin
						crosses_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign crosses = rsp_crosses_q;
	assign table_full = rsp_full_q;
	assign stored_count = rsp_count_q;

endmodule

@@ src/scc_checker.sv @@
// Port-level assertions for the segment crossing checker and their bind.
module scc_checker
	import scc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input logic             crosses,
	input logic             table_full,
	input logic [CNT_W-1:0] stored_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(crosses) && $stable(table_full) &&
		$stable(stored_count))
		else $error("response payload changed while stalled");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> stored_count == CNT_W'(MAX_SEGMENTS))
		else $error("refused insert without a full table");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && table_full |-> !crosses)
		else $error("refused insert also reports a crossing");

	a_cross_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && crosses |-> stored_count != '0)
		else $error("crossing reported against an empty table");

endmodule

bind segment_crossing_checker scc_checker u_scc_checker (.*);
